@@ sv/imdu_pkg.sv @@
// ----------------------------------------------------------------------------
// imdu_pkg
// Shared types and constants of the integer multiply/divide unit.
// ----------------------------------------------------------------------------
package imdu_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int RES_WIDTH      = 32;
	localparam int OP_WIDTH       = 2;

	localparam logic [OP_WIDTH-1:0] OP_QUOT = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_REM  = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_MUL  = 2'd2;

	typedef logic [OP_WIDTH-1:0] op_t;

	// status of the serial core as seen by the output stage
	typedef struct packed {
		logic busy;
		logic done;
	} imdu_stat_t;

endpackage

@@ sv/imdu_core.sv @@
// ----------------------------------------------------------------------------
// imdu_core
// Radix-2 serial engine: shift-add multiply or restoring divide, one
// operand bit per cycle, result held until the output stage takes it.
// ----------------------------------------------------------------------------
module imdu_core #(
	parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  imdu_pkg::op_t         op,
	input  logic [DATA_WIDTH-1:0] opa,
	input  logic [DATA_WIDTH-1:0] opb,
	input  logic                  take,
	output imdu_pkg::imdu_stat_t  stat,
	output logic [DATA_WIDTH-1:0] res
);
	import imdu_pkg::*;

	localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	op_t                   op_q;
	logic                  bzero_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] acc_q;

	logic [DATA_WIDTH:0]   rem_shift;
	logic [DATA_WIDTH+1:0] diff;
	logic                  ge;
	logic [DATA_WIDTH-1:0] div_acc;
	logic [DATA_WIDTH-1:0] mul_acc;

	// restoring divide step: bring in next dividend bit, try subtract
	assign rem_shift = {acc_q, a_q[DATA_WIDTH-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, b_q};
	assign ge        = ~diff[DATA_WIDTH+1];
	assign div_acc   = ge ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];

	// shift-add multiply step, low word only
	assign mul_acc = acc_q + (b_q[0] ? a_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (take && start) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
					end else if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q    <= op;
			bzero_q <= (opb == '0);
			a_q     <= opa;
			b_q     <= opb;
			acc_q   <= '0;
		end else if (state_q == ST_RUN) begin
			if (op_q == OP_MUL) begin
				acc_q <= mul_acc;
				a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
				b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
			end else begin
				acc_q <= div_acc;
				a_q   <= {a_q[DATA_WIDTH-2:0], ge};
			end
		end
	end

	always_comb begin
		unique case (op_q)
			OP_QUOT: res = bzero_q ? '0 : a_q;
			OP_REM:  res = acc_q;
			OP_MUL:  res = acc_q;
			default: res = '0;
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

`ifndef NO_ASSERTIONS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_RUN))
		else $error("core did not enter run after start");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !take) |=> (state_q == ST_DONE) && $stable(res))
		else $error("finished result changed before transfer");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_DONE))
		else $error("iteration count overran");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q != OP_MUL && !bzero_q) |-> (acc_q < b_q))
		else $error("remainder not below divisor");
`endif

endmodule

@@ sv/integer_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// integer_mul_div_unit
// Serial unsigned divide / remainder / low-word multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries req_type, operand_a, operand_b;
//   the output channel (out_valid/out_stall) returns one result per request.
//   req_type: quotient, remainder or low product word; an unused code gives 0.
//   Division by zero gives quotient 0 and remainder equal to operand_a.
// Timing:
//   The serial core retires one operand bit per cycle while a request runs,
//   then hands the finished result to the output register behind out_valid.
//   It takes the next request in the cycle that result is handed off, not
//   before; the multiply add and the divide subtract are separate steps.
// Stalls:
//   A finished result moves into the output register, so the core takes the
//   next request while that result waits. If the output register is still
//   full, the core holds its result and in_stall stays high.
// Reset:
//   arst_n clears the core state and the output valid; a request in flight
//   is dropped, none is invented across reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_mul_div_unit #(
	parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  imdu_pkg::op_t                     req_type,
	input  logic [DATA_WIDTH-1:0]             operand_a,
	input  logic [DATA_WIDTH-1:0]             operand_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [imdu_pkg::RES_WIDTH-1:0]    result
);
	import imdu_pkg::*;

	imdu_stat_t            stat;
	logic [DATA_WIDTH-1:0] core_res;
	logic                  take;
	logic                  start;
	logic                  out_valid_q;
	logic [RES_WIDTH-1:0]  result_q;

	// move a finished result when the output register is empty or draining
	assign take     = stat.done && (!out_valid_q || !out_stall);
	assign in_stall = stat.busy && !(stat.done && take);
	assign start    = in_valid && !in_stall;

	imdu_core #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req_type),
		.opa    (operand_a),
		.opb    (operand_b),
		.take   (take),
		.stat   (stat),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= RES_WIDTH'(core_res);
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

@@ sim/tb_integer_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// tb_integer_mul_div_unit
// Self-checking bench for the serial divide / remainder / multiply unit.
// A queue-fed driver offers requests on the input channel and a monitor checks
// every returned word against a scoreboard that an in-bench calculator fills
// at each input transfer. The run has a directed set of corner operands and
// three random phases with changing idle rates, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_integer_mul_div_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import imdu_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam op_t OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 195;

	typedef struct {
		op_t          op;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} mdu_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	op_t                  req_type = OP_QUOT;
	logic [W-1:0]         operand_a = '0;
	logic [W-1:0]         operand_b = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [RES_WIDTH-1:0] result;

	mdu_req_t             request_q[$];
	logic [RES_WIDTH-1:0] predicted_results[$];
	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   accepted_cnt = 0;
	int                   err_cnt = 0;
	logic                 hold_off = 1'b0;

	integer_mul_div_unit #(
		.DATA_WIDTH(W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected word for one request
	function automatic logic [RES_WIDTH-1:0] calc_result(op_t op, logic [W-1:0] a,
			logic [W-1:0] b);
		logic [W-1:0] word;
		case (op)
			OP_QUOT: word = (b == '0) ? '0 : a / b;
			OP_REM:  word = (b == '0) ? a : a % b;
			OP_MUL:  word = a * b;
			default: word = '0;
		endcase
		return word[RES_WIDTH-1:0];
	endfunction

	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] one;
		one = {{(W-1){1'b0}}, 1'b1};
		case ($urandom_range(0, 5))
			0: return W'($urandom_range(0, 15));
			1: return {W{1'b1}} - W'($urandom_range(0, 15));
			2: return one << $urandom_range(0, W - 1);
			default: return W'($urandom);
		endcase
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 15);
		if (r < 5)
			return OP_QUOT;
		else if (r < 10)
			return OP_REM;
		else if (r < 15)
			return OP_MUL;
		return OP_UNUSED;
	endfunction

	task automatic add_request(op_t op, logic [W-1:0] a, logic [W-1:0] b);
		mdu_req_t req;
		req.op = op;
		req.a  = a;
		req.b  = b;
		request_q.push_back(req);
	endtask

	// input side: hold a stalled request, otherwise offer the next one or idle
	always @(posedge clk or negedge arst_n) begin : drive
		mdu_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_results.push_back(calc_result(req_type, operand_a, operand_b));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (in_valid && in_stall) begin
				// hold payload until the transfer
			end else if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = request_q.pop_front();
				in_valid  <= 1'b1;
				req_type  <= nxt.op;
				operand_a <= nxt.a;
				operand_b <= nxt.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: check each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		logic [RES_WIDTH-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					if (err_cnt < 10)
						$display("%0t: unexpected result %h", $realtime, result);
					err_cnt <= err_cnt + 1;
				end else begin
					want = predicted_results.pop_front();
					if (result !== want) begin
						if (err_cnt < 10)
							$display("%0t: result mismatch: expected %h, got %h",
								$realtime, want, result);
						err_cnt <= err_cnt + 1;
					end
				end
			end
			out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// long hold-off on the output while requests keep coming, to back up the unit
	initial begin
		wait (accepted_cnt >= 480);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_integer_mul_div_unit failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct <= 11;
		recv_idle_pct <= 85;
		@(negedge clk);
		// directed corners: extremes, wrap, divide by zero, unused code
		add_request(OP_MUL, '0, '0);
		add_request(OP_MUL, {W{1'b1}}, {W{1'b1}});
		add_request(OP_MUL, {W{1'b1}}, 32'd2);
		add_request(OP_MUL, 32'h8000_0000, 32'd2);
		add_request(OP_MUL, 32'hFFFF_FFFE, 32'd3);
		add_request(OP_MUL, 32'h0001_0000, 32'h0001_0000);
		add_request(OP_QUOT, 32'h1234_5678, '0);
		add_request(OP_REM, 32'h1234_5678, '0);
		add_request(OP_QUOT, {W{1'b1}}, '0);
		add_request(OP_REM, {W{1'b1}}, '0);
		add_request(OP_QUOT, {W{1'b1}}, 32'd1);
		add_request(OP_REM, {W{1'b1}}, 32'd1);
		add_request(OP_QUOT, {W{1'b1}}, {W{1'b1}});
		add_request(OP_REM, 32'd7, {W{1'b1}});
		add_request(OP_QUOT, '0, 32'd5);
		add_request(OP_QUOT, 32'd5, 32'd7);
		add_request(OP_REM, 32'd100, 32'd7);
		add_request(OP_QUOT, 32'h8000_0000, 32'h8000_0001);
		add_request(OP_UNUSED, {W{1'b1}}, {W{1'b1}});
		add_request(OP_UNUSED, 32'h5A5A_A5A5, '0);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct <= 85;
				recv_idle_pct <= 11;
			end else if (phase == 2) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			@(negedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_request(pick_op(), pick_operand(), pick_operand());
			while (request_q.size() > 0 || in_valid || predicted_results.size() > 0)
				@(posedge clk);
		end

		// let any straggler surface
		repeat (W + 8) @(posedge clk);
		if (err_cnt == 0 && predicted_results.size() == 0)
			$display("tb_integer_mul_div_unit passed");
		else
			$display("tb_integer_mul_div_unit failed");
		$finish;
	end

endmodule
